// ===== design/spfs_pkg.sv =====
`timescale 1ns / 1ps

package spfs_pkg;

    // Field widths
    localparam int POS_W      = 24;
    localparam int HALF_W     = 22;
    localparam int HOVER_W    = 23;
    localparam int STEP_W     = 22;
    localparam int CNT_W      = 12;
    localparam int TICK_W     = 10;
    localparam int PHASE_W    = 2;

    // Path point before the offset is added, and the sum with the offset
    localparam int PT_W       = 37;
    localparam int SUM_W      = 38;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_WIDTH  = 3'd6;

    // Stream word widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    typedef struct packed {
        logic        [HALF_W-1:0]  half_length;
        logic        [HALF_W-1:0]  half_width;
        logic signed [HOVER_W-1:0] hover_height;
        logic        [STEP_W-1:0]  length_step;
        logic        [STEP_W-1:0]  width_step;
        logic        [CNT_W-1:0]   points_length;
        logic        [CNT_W-1:0]   points_width;
    } cfg_t;

    typedef struct packed {
        logic                    armed;
        logic                    offboard_mode;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } item_t;

    typedef struct packed {
        logic                    sp_valid;
        logic signed [PT_W-1:0]  tx;
        logic signed [PT_W-1:0]  ty;
        logic signed [PT_W-1:0]  tz;
        logic signed [POS_W-1:0] off_x;
        logic signed [POS_W-1:0] off_y;
        logic signed [POS_W-1:0] off_z;
        logic [PHASE_W-1:0]      phase;
    } point_t;

endpackage

// ===== design/spfs_cfg.sv =====
`timescale 1ns / 1ps

module spfs_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [spfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output spfs_pkg::cfg_t                 cfg
);
    import spfs_pkg::*;

    localparam logic [HALF_W-1:0]  RST_HALF   = HALF_W'(1000);
    localparam logic [HOVER_W-1:0] RST_HOVER  = HOVER_W'(1000);
    localparam logic [STEP_W-1:0]  RST_STEP   = STEP_W'(13);
    localparam logic [CNT_W-1:0]   RST_POINTS = CNT_W'(150);

    cfg_t cfg_reg;

    // Register file; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_length   <= RST_HALF;
            cfg_reg.half_width    <= RST_HALF;
            cfg_reg.hover_height  <= RST_HOVER;
            cfg_reg.length_step   <= RST_STEP;
            cfg_reg.width_step    <= RST_STEP;
            cfg_reg.points_length <= RST_POINTS;
            cfg_reg.points_width  <= RST_POINTS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_LENGTH:   cfg_reg.half_length   <= cfg_data[HALF_W-1:0];
                REG_HALF_WIDTH:    cfg_reg.half_width    <= cfg_data[HALF_W-1:0];
                REG_HOVER_HEIGHT:  cfg_reg.hover_height  <= cfg_data[HOVER_W-1:0];
                REG_LENGTH_STEP:   cfg_reg.length_step   <= cfg_data[STEP_W-1:0];
                REG_WIDTH_STEP:    cfg_reg.width_step    <= cfg_data[STEP_W-1:0];
                REG_POINTS_LENGTH: cfg_reg.points_length <= cfg_data[CNT_W-1:0];
                REG_POINTS_WIDTH:  cfg_reg.points_width  <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/spfs_ctrl.sv =====
`timescale 1ns / 1ps

module spfs_ctrl #(
    parameter int TAKEOFF_TICKS   = 200,
    parameter int MOVE_END_TICKS  = 600,
    parameter int MAX_SIDE_POINTS = 4095
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  spfs_pkg::cfg_t   cfg,
    input  logic             item_valid,
    output logic             item_ready,
    input  spfs_pkg::item_t  item,
    output logic             pt_valid,
    input  logic             pt_ready,
    output spfs_pkg::point_t pt
);
    import spfs_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT_DISARM = 2'd0,
        PH_WAIT_ARM    = 2'd1,
        PH_TAKEOFF     = 2'd2,
        PH_PATH        = 2'd3
    } phase_t;

    localparam logic [TICK_W-1:0] TAKEOFF_LIM = TICK_W'(TAKEOFF_TICKS);
    localparam logic [TICK_W-1:0] MOVE_LIM    = TICK_W'(MOVE_END_TICKS);
    localparam logic [TICK_W-1:0] TICK_SAT    = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX     = CNT_W'(MAX_SIDE_POINTS);
    localparam logic [CNT_W-1:0]  CNT_ONE     = CNT_W'(1);

    // Mission state
    phase_t                  phase_reg, phase_next;
    logic [TICK_W-1:0]       ticks_reg, ticks_next;
    logic signed [POS_W-1:0] off_x_reg, off_x_next;
    logic signed [POS_W-1:0] off_y_reg, off_y_next;
    logic signed [POS_W-1:0] off_z_reg, off_z_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [1:0]              side_reg, side_next;
    logic                    prev_armed_reg, prev_offb_reg;

    // Point register towards the output stage
    logic                    pt_valid_reg;
    point_t                  pt_reg, pt_next;

    logic                    step;
    logic                    restart;
    phase_t                  phase_cur;
    logic [CNT_W-1:0]        pl, pw, cnt;
    logic [CNT_W-1:0]        x_mul_a, y_mul_a;
    logic [CNT_W+STEP_W-1:0] x_prod, y_prod;
    logic signed [PT_W-1:0]  xp, yp, hl, hw, hgt;
    logic signed [PT_W-1:0]  path_x, path_y;
    logic [CNT_W-1:0]        idx_inc;
    logic                    idx_wrap;

    assign item_ready = !pt_valid_reg || pt_ready;
    assign step       = item_valid && item_ready;

    // Side counts: zero counts as one, large counts are capped.
    always_comb
    begin
        if (cfg.points_length == '0)
            pl = CNT_ONE;
        else if (cfg.points_length > CNT_MAX)
            pl = CNT_MAX;
        else
            pl = cfg.points_length;

        if (cfg.points_width == '0)
            pw = CNT_ONE;
        else if (cfg.points_width > CNT_MAX)
            pw = CNT_MAX;
        else
            pw = cfg.points_width;
    end

    // Rectangle point for the current side and index.
    // Sides 0 and 2 walk along x, sides 1 and 3 along y.
    assign x_mul_a = side_reg[0] ? (pl - CNT_ONE) : idx_reg;
    assign y_mul_a = (side_reg == 2'd2) ? (pw - CNT_ONE) : idx_reg;
    assign x_prod  = x_mul_a * cfg.length_step;
    assign y_prod  = y_mul_a * cfg.width_step;

    assign xp  = signed'(PT_W'(x_prod));
    assign yp  = signed'(PT_W'(y_prod));
    assign hl  = signed'(PT_W'(cfg.half_length));
    assign hw  = signed'(PT_W'(cfg.half_width));
    assign hgt = PT_W'($signed(cfg.hover_height));

    always_comb
    begin
        path_x = side_reg[1] ? (hl - xp) : (xp - hl);
        case (side_reg)
            2'd0:    path_y = -hw;
            2'd3:    path_y = hw - yp;
            default: path_y = yp - hw;
        endcase
    end

    // Index advance with wrap at the side count or at the counter limit.
    assign cnt      = side_reg[0] ? pw : pl;
    assign idx_inc  = idx_reg + CNT_ONE;
    assign idx_wrap = (idx_inc >= cnt) || (idx_inc == '0);

    assign restart   = (prev_armed_reg && !item.armed) || (prev_offb_reg && !item.offboard_mode);
    assign phase_cur = restart ? PH_WAIT_DISARM : phase_reg;

    // Phase actions for one tick
    always_comb
    begin
        phase_next = phase_cur;
        ticks_next = ticks_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        off_z_next = off_z_reg;
        idx_next   = idx_reg;
        side_next  = side_reg;

        pt_next.sp_valid = 1'b0;
        pt_next.tx       = '0;
        pt_next.ty       = '0;
        pt_next.tz       = '0;

        case (phase_cur)
            PH_WAIT_DISARM:
            begin
                if (!item.armed && !item.offboard_mode)
                    phase_next = PH_WAIT_ARM;
            end
            PH_WAIT_ARM:
            begin
                off_x_next       = item.pos_x;
                off_y_next       = item.pos_y;
                off_z_next       = item.pos_z;
                pt_next.sp_valid = 1'b1;
                pt_next.tz       = hgt;
                if (item.armed && item.offboard_mode)
                begin
                    idx_next   = '0;
                    side_next  = 2'd0;
                    ticks_next = '0;
                    phase_next = PH_TAKEOFF;
                end
            end
            PH_TAKEOFF:
            begin
                if (ticks_reg < TAKEOFF_LIM)
                begin
                    pt_next.sp_valid = 1'b1;
                    pt_next.tz       = hgt;
                end
                else if (ticks_reg < MOVE_LIM)
                begin
                    pt_next.sp_valid = 1'b1;
                    pt_next.tx       = -hl;
                    pt_next.ty       = -hw;
                    pt_next.tz       = hgt;
                end
                else
                begin
                    phase_next = PH_PATH;
                end
                if (ticks_reg != TICK_SAT)
                    ticks_next = ticks_reg + TICK_W'(1);
            end
            PH_PATH:
            begin
                pt_next.sp_valid = 1'b1;
                pt_next.tx       = path_x;
                pt_next.ty       = path_y;
                pt_next.tz       = hgt;
                if (idx_wrap)
                begin
                    idx_next  = '0;
                    side_next = side_reg + 2'd1;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default: ;
        endcase

        pt_next.off_x = off_x_next;
        pt_next.off_y = off_y_next;
        pt_next.off_z = off_z_next;
        pt_next.phase = phase_next;
    end

    // State and point register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_DISARM;
            ticks_reg      <= '0;
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            off_z_reg      <= '0;
            idx_reg        <= '0;
            side_reg       <= 2'd0;
            prev_armed_reg <= 1'b0;
            prev_offb_reg  <= 1'b0;
            pt_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_ready)
                pt_valid_reg <= item_valid;
            if (step)
            begin
                phase_reg      <= phase_next;
                ticks_reg      <= ticks_next;
                off_x_reg      <= off_x_next;
                off_y_reg      <= off_y_next;
                off_z_reg      <= off_z_next;
                idx_reg        <= idx_next;
                side_reg       <= side_next;
                prev_armed_reg <= item.armed;
                prev_offb_reg  <= item.offboard_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            pt_reg <= pt_next;
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    // A tick that ends in the first phase never issues a setpoint.
    a_no_sp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid_reg && pt_reg.phase == PH_WAIT_DISARM) |-> !pt_reg.sp_valid)
        else $error("setpoint issued while waiting for disarm");

    // The stored index always stays below the side limit.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < CNT_MAX || idx_reg == '0)
        else $error("side index beyond limit");

    // The path phase is entered from takeoff only once the move has ended.
    a_path_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_cur == PH_TAKEOFF && phase_next == PH_PATH) |-> ticks_reg >= MOVE_LIM)
        else $error("path phase entered early");

    // A tick that stays in the path phase always yields a setpoint.
    a_path_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_cur == PH_PATH) |=> (pt_valid_reg && pt_reg.sp_valid))
        else $error("path tick without setpoint");

endmodule

// ===== design/spfs_out.sv =====
`timescale 1ns / 1ps

module spfs_out
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pt_valid,
    output logic                               pt_ready,
    input  spfs_pkg::point_t                   pt,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [spfs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tuser
);
    import spfs_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - 3 * POS_W - PHASE_W;
    localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] POS_LO = SUM_W'(-8388608);

    logic                    out_v_reg;
    logic [OUT_TDATA_W-1:0]  tdata_reg, tdata_next;
    logic                    tuser_reg;
    logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
    logic signed [POS_W-1:0] sat_x, sat_y, sat_z;
    logic                    load;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_HI)
            r = POS_HI[POS_W-1:0];
        else if (v < POS_LO)
            r = POS_LO[POS_W-1:0];
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    assign pt_ready = !out_v_reg || m_tready;
    assign load     = pt_valid && pt_ready;

    // Add the latched offset and saturate once to the output range; words without a setpoint carry zeros.
    assign sum_x = SUM_W'(pt.tx) + SUM_W'(pt.off_x);
    assign sum_y = SUM_W'(pt.ty) + SUM_W'(pt.off_y);
    assign sum_z = SUM_W'(pt.tz) + SUM_W'(pt.off_z);

    always_comb
    begin
        if (pt.sp_valid)
        begin
            sat_x = sat_pos(sum_x);
            sat_y = sat_pos(sum_y);
            sat_z = sat_pos(sum_z);
        end
        else
        begin
            sat_x = '0;
            sat_y = '0;
            sat_z = '0;
        end
        tdata_next = {{PAD_W{1'b0}}, pt.phase, sat_z, sat_y, sat_x};
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (pt_ready)
            out_v_reg <= pt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= pt.sp_valid;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

// ===== design/square_path_flight_sequencer.sv =====
`timescale 1ns / 1ps

// Square path flight sequencer.
// Input stream s_*: one word per control tick with the armed and offboard
// flags and the measured position. Output stream m_*: exactly one word per
// input word, carrying the setpoint, its valid flag in m_tuser and the
// mission phase after the tick.
// The configuration port writes one register per cycle when cfg_we is high;
// the user must write it only while no words are in flight, as the block
// does not enforce this. The edge that accepts a word loads the input
// register; the word then passes the point and output registers before it
// appears on m_tvalid. Throughput: one word per cycle while m_tready is
// held high; the mission state and the path point are worked out
// combinationally between the input and point registers, with one
// 12 by 22 bit multiplier per axis.
// Reset clears the mission state to the first phase, the latched offset to
// zero and the configuration registers to their defaults; no words are held.
// When the receiver stalls, the output register holds its word and the
// point and input registers still take one word each before s_tready falls.
module square_path_flight_sequencer #(
    parameter int TAKEOFF_TICKS   = 200,
    parameter int MOVE_END_TICKS  = 600,
    parameter int MAX_SIDE_POINTS = 4095
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // armed, offboard_mode, pos_x, pos_y, pos_z, zero fill
    input  logic [spfs_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // setpoint_x, setpoint_y, setpoint_z, phase, zero fill
    output logic [spfs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // setpoint_valid
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [spfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import spfs_pkg::*;

    cfg_t   cfg;
    item_t  in_item_reg, in_item_next;
    logic   in_v_reg;
    logic   item_ready;
    logic   pt_valid, pt_ready;
    point_t pt;

    // Unpack the input word
    assign in_item_next.armed         = s_tdata[0];
    assign in_item_next.offboard_mode = s_tdata[1];
    assign in_item_next.pos_x         = s_tdata[2 +: POS_W];
    assign in_item_next.pos_y         = s_tdata[2 + POS_W +: POS_W];
    assign in_item_next.pos_z         = s_tdata[2 + 2 * POS_W +: POS_W];

    assign s_tready = !in_v_reg || item_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (s_tready)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= in_item_next;
    end

    spfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spfs_ctrl #(
        .TAKEOFF_TICKS   (TAKEOFF_TICKS),
        .MOVE_END_TICKS  (MOVE_END_TICKS),
        .MAX_SIDE_POINTS (MAX_SIDE_POINTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_v_reg),
        .item_ready (item_ready),
        .item       (in_item_reg),
        .pt_valid   (pt_valid),
        .pt_ready   (pt_ready),
        .pt         (pt)
    );

    spfs_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (pt_valid),
        .pt_ready (pt_ready),
        .pt       (pt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import spfs_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAKEOFF_END   = 200;
    localparam int MOVE_END      = 600;
    localparam int SIDE_LIMIT    = 4095;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_TICKS = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_LIMIT  = 10;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam logic [POS_W-1:0] POS_TOP    = 24'h7FFFFF;
    localparam logic [POS_W-1:0] POS_BOTTOM = 24'h800000;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT_DISARM,
        PH_WAIT_ARM,
        PH_FLIGHT,
        PH_PATH
    } mission_phase_e;

    typedef enum {
        CHUNK_NOISE,
        CHUNK_GROUND,
        CHUNK_FLIGHT
    } chunk_e;

    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   z;
        logic [PHASE_W-1:0] phase;
    } setpoint_word_t;

    // Mission sequencer mirror: works out the setpoint for every tick and
    // holds the setpoints still owed by the block, oldest first.
    class setpoint_scoreboard;
        logic        [HALF_W-1:0]  half_length;
        logic        [HALF_W-1:0]  half_width;
        logic signed [HOVER_W-1:0] hover_height;
        logic        [STEP_W-1:0]  length_step;
        logic        [STEP_W-1:0]  width_step;
        logic        [CNT_W-1:0]   points_length;
        logic        [CNT_W-1:0]   points_width;

        mission_phase_e          stage;
        logic [TICK_W-1:0]       flight_ticks;
        logic signed [POS_W-1:0] anchor_x;
        logic signed [POS_W-1:0] anchor_y;
        logic signed [POS_W-1:0] anchor_z;
        logic [CNT_W-1:0]        side_index;
        logic [1:0]              side_number;
        logic                    was_armed;
        logic                    was_offboard;

        setpoint_word_t setpoints_due[$];
        int             mismatches;

        function new();
            half_length   = 1000;
            half_width    = 1000;
            hover_height  = 1000;
            length_step   = 13;
            width_step    = 13;
            points_length = 150;
            points_width  = 150;
            stage         = PH_WAIT_DISARM;
            flight_ticks  = '0;
            anchor_x      = '0;
            anchor_y      = '0;
            anchor_z      = '0;
            side_index    = '0;
            side_number   = '0;
            was_armed     = 1'b0;
            was_offboard  = 1'b0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_HALF_LENGTH:   half_length   = data[HALF_W-1:0];
                REG_HALF_WIDTH:    half_width    = data[HALF_W-1:0];
                REG_HOVER_HEIGHT:  hover_height  = data[HOVER_W-1:0];
                REG_LENGTH_STEP:   length_step   = data[STEP_W-1:0];
                REG_WIDTH_STEP:    width_step    = data[STEP_W-1:0];
                REG_POINTS_LENGTH: points_length = data[CNT_W-1:0];
                REG_POINTS_WIDTH:  points_width  = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // A count of zero means one point; counts are capped at the side limit.
        function longint side_count(logic [CNT_W-1:0] n);
            if (n == 0)
                return 1;
            if (n > SIDE_LIMIT)
                return SIDE_LIMIT;
            return longint'(n);
        endfunction

        function logic [POS_W-1:0] clamp_pos(longint v);
            if (v > 64'sd8388607)
                return POS_TOP;
            if (v < -64'sd8388608)
                return POS_BOTTOM;
            return v[POS_W-1:0];
        endfunction

        function void predict_setpoint(logic armed, logic offboard,
                                       logic signed [POS_W-1:0] px,
                                       logic signed [POS_W-1:0] py,
                                       logic signed [POS_W-1:0] pz);
            longint         hl;
            longint         hw;
            longint         h;
            longint         ls;
            longint         ws;
            longint         pl;
            longint         pw;
            longint         tx;
            longint         ty;
            longint         tz;
            longint         i;
            longint         cnt;
            logic           valid;
            setpoint_word_t sp;

            hl    = longint'(half_length);
            hw    = longint'(half_width);
            h     = longint'(hover_height);
            ls    = longint'(length_step);
            ws    = longint'(width_step);
            pl    = side_count(points_length);
            pw    = side_count(points_width);
            tx    = 0;
            ty    = 0;
            tz    = 0;
            valid = 1'b0;

            // A falling armed or offboard flag restarts the mission
            if ((was_armed && !armed) || (was_offboard && !offboard))
                stage = PH_WAIT_DISARM;

            case (stage)
                PH_WAIT_DISARM:
                begin
                    if (!armed && !offboard)
                        stage = PH_WAIT_ARM;
                end
                PH_WAIT_ARM:
                begin
                    anchor_x = px;
                    anchor_y = py;
                    anchor_z = pz;
                    tz       = h;
                    valid    = 1'b1;
                    if (armed && offboard)
                    begin
                        side_index   = '0;
                        side_number  = '0;
                        flight_ticks = '0;
                        stage        = PH_FLIGHT;
                    end
                end
                PH_FLIGHT:
                begin
                    // Climb straight up, then fly to the start corner
                    if (flight_ticks < TAKEOFF_END)
                    begin
                        tz    = h;
                        valid = 1'b1;
                    end
                    else if (flight_ticks < MOVE_END)
                    begin
                        tx    = -hl;
                        ty    = -hw;
                        tz    = h;
                        valid = 1'b1;
                    end
                    else
                        stage = PH_PATH;
                    if (flight_ticks != '1)
                        flight_ticks = flight_ticks + 1'b1;
                end
                default:
                begin
                    // Walk the rectangle one point per tick
                    i = longint'(side_index);
                    case (side_number)
                        2'd0:
                        begin
                            tx  = -hl + i * ls;
                            ty  = -hw;
                            cnt = pl;
                        end
                        2'd1:
                        begin
                            tx  = -hl + (pl - 1) * ls;
                            ty  = -hw + i * ws;
                            cnt = pw;
                        end
                        2'd2:
                        begin
                            tx  = hl - i * ls;
                            ty  = -hw + (pw - 1) * ws;
                            cnt = pl;
                        end
                        default:
                        begin
                            tx  = hl - (pl - 1) * ls;
                            ty  = hw - i * ws;
                            cnt = pw;
                        end
                    endcase
                    tz         = h;
                    valid      = 1'b1;
                    side_index = side_index + 1'b1;
                    if (longint'(side_index) >= cnt || side_index == 0)
                    begin
                        side_index  = '0;
                        side_number = side_number + 1'b1;
                    end
                end
            endcase

            was_armed    = armed;
            was_offboard = offboard;

            sp.valid = valid;
            sp.x     = valid ? clamp_pos(tx + longint'(anchor_x)) : '0;
            sp.y     = valid ? clamp_pos(ty + longint'(anchor_y)) : '0;
            sp.z     = valid ? clamp_pos(tz + longint'(anchor_z)) : '0;
            sp.phase = stage;
            setpoints_due = {setpoints_due, sp};
        endfunction

        function void check_setpoint(setpoint_word_t got);
            setpoint_word_t want;

            if (setpoints_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected setpoint word: valid=%0d x=%0d y=%0d z=%0d phase=%0d",
                             got.valid, $signed(got.x), $signed(got.y), $signed(got.z),
                             got.phase);
                return;
            end
            want = setpoints_due.pop_front();
            if (got.valid !== want.valid || got.x !== want.x || got.y !== want.y ||
                got.z !== want.z || got.phase !== want.phase)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("setpoint mismatch: expected valid=%0d x=%0d y=%0d z=%0d phase=%0d",
                             want.valid, $signed(want.x), $signed(want.y), $signed(want.z),
                             want.phase);
                    $display("                   got      valid=%0d x=%0d y=%0d z=%0d phase=%0d",
                             got.valid, $signed(got.x), $signed(got.y), $signed(got.z),
                             got.phase);
                end
            end
        endfunction

        // Setpoints never delivered count as failures too
        function int close_out();
            if (setpoints_due.size() != 0)
                $display("%0d setpoint words never arrived", setpoints_due.size());
            mismatches += setpoints_due.size();
            return mismatches;
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    setpoint_scoreboard sb;

    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    logic   hold_req      = 1'b0;
    logic   hold_taken    = 1'b0;
    int     hold_left     = 0;
    int     cycle_count   = 0;
    chunk_e chunk         = CHUNK_FLIGHT;
    int     chunk_left    = 0;
    int     failures;

    square_path_flight_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("square_path_flight_sequencer regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            m_tready   <= 1'b0;
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch both streams; every accepted word goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.predict_setpoint(s_tdata[0], s_tdata[1], s_tdata[25:2],
                                    s_tdata[49:26], s_tdata[73:50]);
            if (m_tvalid && m_tready)
                sb.check_setpoint({m_tuser, m_tdata[23:0], m_tdata[47:24],
                                   m_tdata[71:48], m_tdata[73:72]});
        end
    end

    task automatic send_tick(logic armed, logic offboard, logic [POS_W-1:0] px,
                             logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - 2 - 3 * POS_W){1'b0}}, pz, py, px, offboard, armed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mostly random positions, with the extremes mixed in
    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(15))
            0:       return POS_TOP;
            1:       return POS_BOTTOM;
            2:       return '0;
            3:       return '1;
            default: return POS_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_span();
        if ($urandom_range(1) != 0)
            return CFG_DATA_W'($urandom());
        return CFG_DATA_W'($urandom_range(5000));
    endfunction

    // Point counts: mostly short sides, sometimes zero or long, with stray upper bits
    function automatic logic [CFG_DATA_W-1:0] rand_count();
        case ($urandom_range(7))
            0:       return CFG_DATA_W'($urandom()) & 23'h7FF000;
            1:       return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(index, data);
    endtask

    // Sender pauses until every setpoint owed has come back; the first edge
    // lets the last accepted word reach the scoreboard.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.setpoints_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic configure(int setting);
        logic [CFG_DATA_W-1:0] hl;
        logic [CFG_DATA_W-1:0] hw;
        logic [CFG_DATA_W-1:0] hov;
        logic [CFG_DATA_W-1:0] ls;
        logic [CFG_DATA_W-1:0] ws;
        logic [CFG_DATA_W-1:0] pl;
        logic [CFG_DATA_W-1:0] pw;

        case (setting)
            0:
            begin
                hl  = 1000;
                hw  = 1000;
                hov = 1000;
                ls  = 13;
                ws  = 13;
                pl  = 150;
                pw  = 150;
            end
            1:
            begin
                hl  = CFG_DATA_W'($urandom_range(3000));
                hw  = CFG_DATA_W'($urandom_range(3000));
                hov = CFG_DATA_W'($urandom_range(4000) - 2000);
                ls  = CFG_DATA_W'($urandom_range(600));
                ws  = CFG_DATA_W'($urandom_range(600));
                pl  = CFG_DATA_W'($urandom_range(1, 4));
                pw  = CFG_DATA_W'($urandom_range(1, 4));
            end
            2:
            begin
                hl  = 23'h3FFFFF;
                hw  = 23'h3FFFFF;
                hov = 23'h3FFFFF;
                ls  = 23'h3FFFFF;
                ws  = 23'h3FFFFF;
                pl  = 23'd4095;
                pw  = 23'd4095;
            end
            3:
            begin
                // Lowest settings; zero counts shrink a long side mid-path
                hl  = '0;
                hw  = '0;
                hov = 23'h400000;
                ls  = '0;
                ws  = '0;
                pl  = '0;
                pw  = '0;
            end
            default:
            begin
                hl  = rand_span();
                hw  = rand_span();
                hov = rand_span();
                ls  = rand_span();
                ws  = rand_span();
                pl  = rand_count();
                pw  = rand_count();
            end
        endcase
        write_reg(REG_HALF_LENGTH, hl);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_HOVER_HEIGHT, hov);
        write_reg(REG_LENGTH_STEP, ls);
        write_reg(REG_WIDTH_STEP, ws);
        write_reg(REG_POINTS_LENGTH, pl);
        write_reg(REG_POINTS_WIDTH, pw);
        write_reg(REG_NONE, CFG_DATA_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // Missions: a little flag noise, a few ground ticks, then a flight that
    // mostly runs long enough to reach the path and sometimes breaks off early.
    task automatic fly(int ticks);
        int   k;
        logic armed;
        logic offboard;

        for (k = 0; k < ticks; k++)
        begin
            while (chunk_left == 0)
            begin
                case (chunk)
                    CHUNK_NOISE:
                    begin
                        chunk      = CHUNK_GROUND;
                        chunk_left = $urandom_range(1, 3);
                    end
                    CHUNK_GROUND:
                    begin
                        chunk      = CHUNK_FLIGHT;
                        chunk_left = ($urandom_range(3) != 0) ?
                                     MOVE_END + 1 + $urandom_range(20, 450) :
                                     $urandom_range(1, MOVE_END + 20);
                    end
                    default:
                    begin
                        chunk      = CHUNK_NOISE;
                        chunk_left = $urandom_range(3);
                    end
                endcase
            end
            case (chunk)
                CHUNK_NOISE:
                begin
                    armed    = 1'($urandom_range(1));
                    offboard = 1'($urandom_range(1));
                end
                CHUNK_GROUND:
                begin
                    armed    = 1'b0;
                    offboard = 1'b0;
                end
                default:
                begin
                    armed    = 1'b1;
                    offboard = 1'b1;
                end
            endcase
            send_tick(armed, offboard, pick_pos(), pick_pos(), pick_pos());
            chunk_left--;
        end
    endtask

    initial
    begin
        int seg;

        sb = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset settings: every flag pattern while waiting to
        // arm and in takeoff, extreme positions latched as offset, restarts.
        send_tick(1'b0, 1'b0, '0, '0, '0);
        send_tick(1'b0, 1'b0, POS_TOP, POS_TOP, POS_TOP);
        send_tick(1'b0, 1'b0, POS_BOTTOM, POS_BOTTOM, POS_BOTTOM);
        send_tick(1'b1, 1'b0, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b1, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b1, 1'b1, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b0, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b0, '1, '1, '1);
        send_tick(1'b1, 1'b1, pick_pos(), pick_pos(), pick_pos());
        repeat (4)
            send_tick(1'b1, 1'b1, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b1, 1'b0, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b0, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b1, 1'b1, POS_TOP, POS_BOTTOM, POS_TOP);
        send_tick(1'b0, 1'b1, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b0, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b1, POS_BOTTOM, POS_TOP, POS_BOTTOM);
        send_tick(1'b1, 1'b1, '0, '0, '0);
        send_tick(1'b1, 1'b1, pick_pos(), pick_pos(), pick_pos());
        send_tick(1'b0, 1'b0, pick_pos(), pick_pos(), pick_pos());

        // Random missions over several settings; the mission carries on
        // across each settings change, so a path can see its counts shrink.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            configure(seg);
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 87;
                end
                default:
                begin
                    send_idle_pct = 23;
                    stall_pct    <= 23;
                end
            endcase
            // Long receiver hold-off while words keep coming
            if (seg == 0)
                hold_req <= 1'b1;
            fly(SEGMENT_TICKS);
        end
        drain();

        failures = sb.close_out();
        if (failures == 0)
            $display("square_path_flight_sequencer regression: pass");
        else
            $display("square_path_flight_sequencer regression: fail");
        $finish;
    end

endmodule
